>>> sv/shp_pkg.sv
package shp_pkg;

   localparam int PIX_BITS       = 8;
   localparam int WIDTH_BITS     = 12;
   localparam int HEIGHT_BITS    = 16;
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MIN_SIZE       = 3;
   localparam int WIDTH_RESET    = 640;
   localparam int HEIGHT_RESET   = 480;
   localparam int SHARPEN_GAIN   = 5;
   localparam int QUEUE_DEPTH    = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic {
      BACK_FIRST  = 1'b0,
      BACK_SECOND = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] pixel;
      logic                dual;
      logic                dual_eof;
   } entry_type;

endpackage

>>> sv/shp_front.sv
module shp_front #(
   parameter int MAX_WIDTH = shp_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [shp_pkg::WIDTH_BITS-1:0]  image_width,
   input  logic [shp_pkg::HEIGHT_BITS-1:0] image_height,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [shp_pkg::PIX_BITS-1:0]    req_tdata,
   output logic                            push,
   output shp_pkg::entry_type              push_data,
   input  logic                            q_ready
);
   import shp_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > WIDTH_BITS) ? CW + 1 : WIDTH_BITS;
   localparam int HW = HEIGHT_BITS + 1;

   logic [PIX_BITS-1:0]    prev_row_ff  [MAX_WIDTH];
   logic [PIX_BITS-1:0]    older_row_ff [MAX_WIDTH];

   logic [CW-1:0]          col_ff, col_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic [CW-1:0]          s1_col_ff;
   logic [PIX_BITS-1:0]    s1_px_ff;
   logic                   s1_has_ff, s1_interior_ff, s1_dual_ff, s1_eof_ff;
   logic [PIX_BITS-1:0]    centre_rd_ff, right_rd_ff, up_rd_ff, left_ff;

   logic [WW-1:0]          width_ext, used_w, col_ext;
   logic [HW-1:0]          height_ext, used_h, row_ext;
   logic                   last_col, last_row, has_rsp, interior;
   logic [CW-1:0]          right_idx;
   logic                   accept, s1_go;
   logic [11:0]            centre_x, neigh;
   logic signed [11:0]     diff;
   logic [PIX_BITS-1:0]    sat;

   always_comb begin
      width_ext  = WW'(image_width);
      height_ext = HW'(image_height);
      if (width_ext < WW'(MIN_SIZE)) begin
         used_w = WW'(MIN_SIZE);
      end else if (width_ext > WW'(MAX_WIDTH)) begin
         used_w = WW'(MAX_WIDTH);
      end else begin
         used_w = width_ext;
      end
      used_h  = (height_ext < HW'(MIN_SIZE)) ? HW'(MIN_SIZE) : height_ext;
      col_ext = WW'(col_ff);
      row_ext = HW'(row_ff);
      last_col = (col_ext + WW'(1)) >= used_w;
      last_row = (row_ext + HW'(1)) >= used_h;
      has_rsp  = (row_ff != '0);
      interior = (row_ff >= HEIGHT_BITS'(2)) && (row_ext <= used_h - HW'(1)) &&
                 (col_ff != '0) && ((col_ext + WW'(2)) <= used_w);
      right_idx = ((col_ext + WW'(1)) >= WW'(MAX_WIDTH)) ? '0 : col_ff + CW'(1);
   end

   assign s1_go      = s1_valid_ff && (!s1_has_ff || q_ready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + HEIGHT_BITS'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // line stores, read before write
   always_ff @(posedge clock) begin
      if (accept) begin
         centre_rd_ff        <= prev_row_ff[col_ff];
         right_rd_ff         <= prev_row_ff[right_idx];
         prev_row_ff[col_ff] <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         up_rd_ff <= older_row_ff[col_ff];
      end
      if (s1_go) begin
         older_row_ff[s1_col_ff] <= centre_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff      <= col_ff;
         s1_px_ff       <= req_tdata;
         s1_has_ff      <= has_rsp;
         s1_interior_ff <= interior;
         s1_dual_ff     <= last_row;
         s1_eof_ff      <= last_col;
      end
      if (s1_go) begin
         left_ff <= centre_rd_ff;
      end
   end

   always_comb begin
      centre_x = 12'(centre_rd_ff) * 12'(SHARPEN_GAIN);
      neigh    = 12'(left_ff) + 12'(right_rd_ff) + 12'(up_rd_ff) + 12'(s1_px_ff);
      diff     = $signed(centre_x) - $signed(neigh);
      if (diff < 0) begin
         sat = '0;
      end else if (diff > 12'sd255) begin
         sat = '1;
      end else begin
         sat = diff[PIX_BITS-1:0];
      end
      push               = s1_go && s1_has_ff;
      push_data.pixel    = s1_interior_ff ? sat : '0;
      push_data.dual     = s1_dual_ff;
      push_data.dual_eof = s1_eof_ff;
   end

endmodule

>>> sv/shp_queue.sv
module shp_queue #(
   parameter int DEPTH = shp_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  shp_pkg::entry_type push_data,
   output logic               q_ready,
   input  logic               pop,
   output logic               q_valid,
   output shp_pkg::entry_type head
);
   import shp_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   entry_type     slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign q_ready = (count_ff != NW'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && q_ready;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + NW'(do_push) - NW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/shp_back.sv
module shp_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  shp_pkg::entry_type           head,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [shp_pkg::PIX_BITS-1:0] rsp_tdata,
   output logic                         rsp_tlast,
   output logic                         rsp_tuser
);
   import shp_pkg::*;

   back_state_type      state_ff, state_in;
   logic                out_valid_ff, out_valid_in;
   logic [PIX_BITS-1:0] out_pixel_ff, out_pixel_in;
   logic                out_eof_ff, out_eof_in;
   logic                out_lir_ff, out_lir_in;
   logic                load;

   assign load = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      if (load && q_valid) begin
         case (state_ff)
            BACK_FIRST:  state_in = head.dual ? BACK_SECOND : BACK_FIRST;
            BACK_SECOND: state_in = BACK_FIRST;
            default:     state_in = BACK_FIRST;
         endcase
      end
   end

   always_comb begin
      pop          = 1'b0;
      out_valid_in = load ? q_valid : out_valid_ff;
      out_pixel_in = out_pixel_ff;
      out_eof_in   = out_eof_ff;
      out_lir_in   = out_lir_ff;
      if (load && q_valid) begin
         case (state_ff)
            BACK_FIRST: begin
               out_pixel_in = head.pixel;
               out_eof_in   = 1'b0;
               out_lir_in   = !head.dual;
               pop          = !head.dual;
            end
            BACK_SECOND: begin
               out_pixel_in = '0;
               out_eof_in   = head.dual_eof;
               out_lir_in   = 1'b1;
               pop          = 1'b1;
            end
            default: begin
               pop = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_pixel_ff <= out_pixel_in;
      out_eof_ff   <= out_eof_in;
      out_lir_ff   <= out_lir_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pixel_ff;
   assign rsp_tlast  = out_eof_ff;
   assign rsp_tuser  = out_lir_ff;

endmodule

>>> sv/sharpen_3x3_laplacian_stream_unit.sv
// 3x3 laplacian sharpening of an 8-bit grayscale raster stream.
// req_*: one pixel per beat in raster order. rsp_*: sharpened pixels, the
// output frame border rows and columns are zero.
// output row r-1 comes out while input row r goes in; the first input row
// gives no beat, each pixel of the last input row gives two beats (its row
// above, then the all-zero bottom row). rsp_tlast marks the final pixel of the
// output frame, rsp_tuser marks the last beat caused by one input pixel.
// image size comes from the csr_* register port (width at 0x0, height at 0x4),
// out-of-range sizes are clamped to 3..MAX_WIDTH and 3..65535.
// throughput: one pixel per cycle while the queue has room, set by the single
// line store pass per pixel; during the last row the rsp side limits it, as
// each pixel there gives two beats.
// a four-entry queue sits between the line store front and the output stage,
// so an rsp stall fills the queue before req_tready drops.
// reset clears counters, queue and output valid; line store contents are
// undefined until the first frame rows are written, with no clearing pass.
module sharpen_3x3_laplacian_stream_unit #(
   parameter int MAX_WIDTH = shp_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [shp_pkg::PIX_BITS-1:0]      req_tdata,   // pixel_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [shp_pkg::PIX_BITS-1:0]      rsp_tdata,   // pixel_out
   output logic                              rsp_tlast,
   output logic                              rsp_tuser,   // last_in_run
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [shp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [shp_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [shp_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import shp_pkg::*;

   logic [WIDTH_BITS-1:0]  width_ff, width_in;
   logic [HEIGHT_BITS-1:0] height_ff, height_in;
   logic                   csr_write;
   reg_index_type          csr_index;
   logic                   push, q_ready, q_valid, pop;
   entry_type              push_data, head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_pwdata[WIDTH_BITS-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_pwdata[HEIGHT_BITS-1:0];
            default:          width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_BITS'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_BITS'(WIDTH_RESET);
         height_ff <= HEIGHT_BITS'(HEIGHT_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   shp_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .image_width  (width_ff),
      .image_height (height_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .push         (push),
      .push_data    (push_data),
      .q_ready      (q_ready)
   );

   shp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .q_ready   (q_ready),
      .pop       (pop),
      .q_valid   (q_valid),
      .head      (head)
   );

   shp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> tb/sharpen_checker.sv
module sharpen_checker #(
   parameter int MAX_WIDTH = shp_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [shp_pkg::PIX_BITS-1:0]      req_tdata,   // pixel_in
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [shp_pkg::PIX_BITS-1:0]      rsp_tdata,   // pixel_out
   input  logic                              rsp_tlast,
   input  logic                              rsp_tuser,   // last_in_run
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [shp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [shp_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                              csr_pready,
   output int unsigned                       pending_count,
   output int unsigned                       fail_count
);
   import shp_pkg::*;

   localparam int COL_BITS = $clog2(MAX_WIDTH);

   typedef struct packed {
      logic [PIX_BITS-1:0] pixel;
      logic                frame_end;
      logic                run_end;
   } sharp_beat_type;

   sharp_beat_type         sharpened_due[$];
   logic [PIX_BITS-1:0]    older_row [MAX_WIDTH];
   logic [PIX_BITS-1:0]    recent_row [MAX_WIDTH];
   logic [COL_BITS-1:0]    col_pos;
   logic [HEIGHT_BITS-1:0] row_pos;
   logic [WIDTH_BITS-1:0]  width_reg;
   logic [HEIGHT_BITS-1:0] height_reg;
   int unsigned            mismatch_count = 0;
   int unsigned            due_count = 0;

   assign pending_count = due_count;
   assign fail_count    = mismatch_count;

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic sharpen_pixel(input logic [PIX_BITS-1:0] px);
      int unsigned    w;
      int unsigned    h;
      int unsigned    c;
      int unsigned    r;
      int             s;
      bit             last_col;
      bit             last_row;
      sharp_beat_type beat;
      w = 32'(width_reg);
      h = 32'(height_reg);
      if (w < MIN_SIZE) w = MIN_SIZE;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < MIN_SIZE) h = MIN_SIZE;
      c = 32'(col_pos);
      r = 32'(row_pos);
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);
      if (r >= 1) begin
         beat.pixel = '0;
         if (r >= 2 && r <= h - 1 && c >= 1 && c + 2 <= w) begin
            // left neighbor was already shifted into the older row
            s = SHARPEN_GAIN * int'(recent_row[c]) - int'(recent_row[c + 1])
                - int'(older_row[c - 1]) - int'(older_row[c]) - int'(px);
            if (s < 0) s = 0;
            if (s > 255) s = 255;
            beat.pixel = PIX_BITS'(s);
         end
         beat.frame_end = 1'b0;
         beat.run_end   = !last_row;
         sharpened_due.push_back(beat);
         if (last_row) begin
            beat.pixel     = '0;
            beat.frame_end = last_col;
            beat.run_end   = 1'b1;
            sharpened_due.push_back(beat);
         end
      end
      if (c < MAX_WIDTH) begin
         older_row[c]  = recent_row[c];
         recent_row[c] = px;
      end
      if (last_col) begin
         col_pos = '0;
         row_pos = last_row ? '0 : HEIGHT_BITS'(r + 1);
      end else begin
         col_pos = COL_BITS'(c + 1);
      end
   endtask

   always @(posedge clock) begin : watch
      sharp_beat_type want;
      if (reset) begin
         sharpened_due.delete();
         col_pos    = '0;
         row_pos    = '0;
         width_reg  = WIDTH_BITS'(WIDTH_RESET);
         height_reg = HEIGHT_BITS'(HEIGHT_RESET);
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[2]))
               REG_IMAGE_WIDTH:  width_reg = csr_pwdata[WIDTH_BITS-1:0];
               REG_IMAGE_HEIGHT: height_reg = csr_pwdata[HEIGHT_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (sharpened_due.size() == 0) begin
               report_mismatch($sformatf("beat with nothing due, pixel_out %0d", rsp_tdata));
            end else begin
               want = sharpened_due.pop_front();
               if (rsp_tdata !== want.pixel) begin
                  report_mismatch($sformatf("pixel_out %0d, expected %0d",
                                            rsp_tdata, want.pixel));
               end
               if (rsp_tlast !== want.frame_end) begin
                  report_mismatch($sformatf("end_of_frame %b, expected %b",
                                            rsp_tlast, want.frame_end));
               end
               if (rsp_tuser !== want.run_end) begin
                  report_mismatch($sformatf("last_in_run %b, expected %b",
                                            rsp_tuser, want.run_end));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            sharpen_pixel(req_tdata);
         end
      end
      due_count <= sharpened_due.size();
   end

endmodule

>>> tb/testbench.sv
module testbench;
   import shp_pkg::*;

   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLDOFF_CYCLES = 300;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [PIX_BITS-1:0]      req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [PIX_BITS-1:0]      rsp_tdata;
   logic                     rsp_tlast;
   logic                     rsp_tuser;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   int unsigned              pending_count;
   int unsigned              fail_count;

   int unsigned tx_idle_pct = 6;
   int unsigned rx_idle_pct = 45;
   int unsigned pixels_sent = 0;
   int unsigned cur_w = MIN_SIZE;
   int unsigned cur_h = MIN_SIZE;
   bit          holdoff_go = 1'b0;
   logic        holding = 1'b0;

   sharpen_3x3_laplacian_stream_unit dut (.*);
   sharpen_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   // long receiver stall so the internal queue fills and req_tready drops
   initial begin : rx_holdoff
      wait (holdoff_go);
      @(posedge clock);
      holding <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      holding <= 1'b0;
   end

   always @(posedge clock) begin
      if (holding) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   function automatic int unsigned pixels_to_frame_end(input int unsigned r,
                                                       input int unsigned c,
                                                       input int unsigned w,
                                                       input int unsigned h);
      int unsigned n;
      n = (c + 1 >= w) ? 1 : w - c;
      if (r + 1 < h) n += (h - 1 - r) * w;
      return n;
   endfunction

   task automatic send_pixel(input logic [PIX_BITS-1:0] value);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      repeat (4) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // minimum sizes are sometimes written as below-minimum aliases
   task automatic set_size(input int unsigned w, input int unsigned h);
      logic [CSR_DATA_BITS-1:0] wv;
      logic [CSR_DATA_BITS-1:0] hv;
      settle();
      wv = w;
      hv = h;
      if (w == MIN_SIZE && $urandom_range(0, 1) == 1) wv = $urandom_range(0, MIN_SIZE);
      if (h == MIN_SIZE && $urandom_range(0, 1) == 1) hv = $urandom_range(0, MIN_SIZE);
      if ($urandom_range(0, 3) == 0) wv = wv | ($urandom() << WIDTH_BITS);
      if ($urandom_range(0, 3) == 0) hv = hv | ($urandom() << HEIGHT_BITS);
      write_reg(REG_IMAGE_WIDTH, wv);
      write_reg(REG_IMAGE_HEIGHT, hv);
      cur_w = w;
      cur_h = h;
   endtask

   task automatic random_frame();
      int unsigned w;
      int unsigned h;
      int unsigned k;
      int unsigned n;
      if ($urandom_range(0, 2) != 0) begin
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(MIN_SIZE, 12);
         h = $urandom_range(MIN_SIZE, 7);
         set_size(w, h);
      end
      n = cur_w * cur_h;
      // broken frame: resize mid-frame, height freely, width only down
      if ($urandom_range(0, 5) == 0) begin
         k = $urandom_range(1, n - 1);
         repeat (k) send_pixel(PIX_BITS'($urandom_range(0, 255)));
         w = $urandom_range(MIN_SIZE, cur_w);
         h = $urandom_range(MIN_SIZE, 7);
         n = pixels_to_frame_end(k / cur_w, k % cur_w, w, h);
         set_size(w, h);
      end
      repeat (n) send_pixel(PIX_BITS'($urandom_range(0, 255)));
   endtask

   initial begin : stimulus
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 4x3 frame, one interior pixel saturates high and one low
      write_reg(REG_IMAGE_WIDTH, 32'd4);
      write_reg(REG_IMAGE_HEIGHT, 32'd1);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            send_pixel((r == 1 && c % 2 == 1) ? 8'hFF : 8'h00);
         end
      end
      settle();

      // tallest frame cut short mid-row by a height write
      write_reg(REG_IMAGE_WIDTH, 32'd1);
      write_reg(REG_IMAGE_HEIGHT, 32'hFFFF);
      repeat (10) send_pixel(PIX_BITS'($urandom_range(0, 255)));
      settle();
      write_reg(REG_IMAGE_HEIGHT, 32'd2);
      repeat (pixels_to_frame_end(3, 1, MIN_SIZE, MIN_SIZE)) begin
         send_pixel(PIX_BITS'($urandom_range(0, 255)));
      end
      settle();

      // widest setting, part of the first row, then shrink both sizes to finish
      write_reg(REG_IMAGE_WIDTH, 32'hFFFF_FFFF);
      write_reg(REG_IMAGE_HEIGHT, 32'hFFFF);
      repeat (100) send_pixel(PIX_BITS'($urandom_range(0, 255)));
      settle();
      write_reg(REG_IMAGE_WIDTH, 32'd3);
      write_reg(REG_IMAGE_HEIGHT, 32'd0);
      repeat (pixels_to_frame_end(0, 100, MIN_SIZE, MIN_SIZE)) begin
         send_pixel(PIX_BITS'($urandom_range(0, 255)));
      end
      cur_w = MIN_SIZE;
      cur_h = MIN_SIZE;

      while (pixels_sent < 280) random_frame();
      tx_idle_pct = 45;
      rx_idle_pct = 6;
      while (pixels_sent < 560) random_frame();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_size(24, 6);
      holdoff_go = 1'b1;
      repeat (24 * 6) send_pixel(PIX_BITS'($urandom_range(0, 255)));
      while (pixels_sent < 850) random_frame();
      settle();

      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/shp_pkg.sv
sv/shp_front.sv
sv/shp_queue.sv
sv/shp_back.sv
sv/sharpen_3x3_laplacian_stream_unit.sv
tb/sharpen_checker.sv
tb/testbench.sv
